// ===== rtl/core/cnss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnss_pkg
// Shared widths, types and helpers for the five-point neighbor sum stencil.
// ----------------------------------------------------------------------------
package cnss_pkg;

	localparam int unsigned ELEM_W    = 16;
	localparam int unsigned SUM_W     = 19;
	localparam int unsigned ROW_W     = 10;
	localparam int unsigned COL_W     = 10;
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned MAX_COLS  = 1024;
	localparam int unsigned MAX_ROWS  = 1024;
	localparam int unsigned Q_DEPTH   = 4;
	localparam int unsigned Q_AW      = 2;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(3);
	localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(4);

	// bit positions in the per-item result mask, in emission order
	localparam int unsigned RES_ABOVE = 0;  // (r-1, c)
	localparam int unsigned RES_LEFT  = 1;  // (r, c-1), last row only
	localparam int unsigned RES_SELF  = 2;  // (r, c), final element only
	localparam int unsigned RES_N     = 3;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_above;
		logic signed [SUM_W-1:0] sum_left;
		logic signed [SUM_W-1:0] sum_self;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic [RES_N-1:0]        has;
	} job_t;

	function automatic logic signed [SUM_W-1:0] sext(input logic [ELEM_W-1:0] v);
		return {{(SUM_W-ELEM_W){v[ELEM_W-1]}}, v};
	endfunction

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
	                                                input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		if (v < CFG_W'(2)) begin
			r = CFG_W'(2);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/cnss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnss_ram
// Generic single-write, single-read RAM; registered read-first output.
// ----------------------------------------------------------------------------
module cnss_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/cnss_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnss_front
// Accepts elements, tracks raster position, runs the two line buffers and
// forms the up-to-three sums each element causes.
// ----------------------------------------------------------------------------
module cnss_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cnss_pkg::CFG_W-1:0]      rows_cfg,
	input  logic [cnss_pkg::CFG_W-1:0]      cols_cfg,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic signed [cnss_pkg::ELEM_W-1:0] element,
	output logic                            job_valid,
	input  logic                            job_ready,
	output cnss_pkg::job_t                  job
);
	import cnss_pkg::*;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             bank_q;   // 1: bank B holds the older row

	logic [CFG_W-1:0] rows_eff, cols_eff, row_inc, col_inc;
	logic [COL_W-1:0] col_nxt;
	logic             accept, last_row, row_end;
	logic [RES_N-1:0] has_d;

	logic             a_we, b_we;
	logic [COL_W-1:0] a_raddr, b_raddr;
	logic [ELEM_W-1:0] a_dout, b_dout;

	logic [ELEM_W-1:0] rec0_q, rec1_q, cur0_q, prev0_q;
	logic [ELEM_W-1:0] winr_q, winc_q;

	// stage 1
	logic             s1_valid_q;
	logic [ELEM_W-1:0] x_s1, rec0_s1, rec1_s1, prev0_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [RES_N-1:0] has_s1;
	logic             up_en_s1, left_en_s1, right_en_s1, lleft_en_s1;
	logic             row_start_s1, bank_s1;

	logic [ELEM_W-1:0] up, right, center, left;
	logic             s1_go;

	always_comb begin
		rows_eff = clamp_size(rows_cfg, CFG_W'(MAX_ROWS));
		cols_eff = clamp_size(cols_cfg, CFG_W'(MAX_COLS));
		row_inc  = {1'b0, row_q} + CFG_W'(1);
		col_inc  = {1'b0, col_q} + CFG_W'(1);
		col_nxt  = col_q + COL_W'(1);
		last_row = (row_inc == rows_eff);
		row_end  = (col_inc >= cols_eff);
		has_d[RES_ABOVE] = (row_q != '0);
		has_d[RES_LEFT]  = last_row && (col_q != '0) && (col_inc <= cols_eff);
		has_d[RES_SELF]  = last_row && (col_inc == cols_eff);
	end

	assign accept     = item_valid && item_ready;
	assign s1_go      = s1_valid_q && ((has_s1 == '0) || job_ready);
	assign item_ready = !s1_valid_q || s1_go;
	assign job_valid  = s1_valid_q && (has_s1 != '0);

	// older bank: read-then-overwrite at col; newer bank: read ahead at col+1
	always_comb begin
		a_we    = accept && !bank_q;
		b_we    = accept && bank_q;
		a_raddr = bank_q ? col_nxt : col_q;
		b_raddr = bank_q ? col_q : col_nxt;
	end

	cnss_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_COLS)) u_bank_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (col_q),
		.wdata (element),
		.re    (accept),
		.raddr (a_raddr),
		.rdata (a_dout)
	);

	cnss_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_COLS)) u_bank_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (col_q),
		.wdata (element),
		.re    (accept),
		.raddr (b_raddr),
		.rdata (b_dout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			bank_q     <= 1'b0;
			s1_valid_q <= 1'b0;
			rec0_q     <= '0;
			rec1_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				rec1_q     <= rec0_q;
				rec0_q     <= element;
				if (row_end) begin
					col_q  <= '0;
					row_q  <= (row_inc >= rows_eff) ? '0 : row_inc[ROW_W-1:0];
					bank_q <= !bank_q;
				end else begin
					col_q <= col_nxt;
				end
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (col_q == '0) begin
				cur0_q <= element;
			end
			if (row_end) begin
				prev0_q <= cur0_q;
			end
			x_s1         <= element;
			rec0_s1      <= rec0_q;
			rec1_s1      <= rec1_q;
			prev0_s1     <= prev0_q;
			row_s1       <= row_q;
			col_s1       <= col_q;
			has_s1       <= has_d;
			up_en_s1     <= (row_q > ROW_W'(1));
			left_en_s1   <= (col_q != '0);
			right_en_s1  <= !row_end;
			lleft_en_s1  <= (col_q > COL_W'(1));
			row_start_s1 <= (col_q == '0);
			bank_s1      <= bank_q;
		end
		if (s1_go) begin
			winr_q <= right;
			winc_q <= center;
		end
	end

	// window over the previous row: left, center from earlier beats, right fresh
	always_comb begin
		up     = bank_s1 ? b_dout : a_dout;
		right  = bank_s1 ? a_dout : b_dout;
		center = row_start_s1 ? prev0_s1 : winr_q;
		left   = winc_q;

		job.sum_above = sext(center) + sext(x_s1)
		              + (up_en_s1    ? sext(up)    : '0)
		              + (left_en_s1  ? sext(left)  : '0)
		              + (right_en_s1 ? sext(right) : '0);
		job.sum_left  = sext(rec0_s1) + sext(x_s1) + sext(left)
		              + (lleft_en_s1 ? sext(rec1_s1) : '0);
		job.sum_self  = sext(x_s1) + sext(rec0_s1) + sext(center);
		job.row       = row_s1;
		job.col       = col_s1;
		job.has       = has_s1;
	end

endmodule

// ===== rtl/core/cnss_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnss_fifo
// Short flop queue of sum jobs between front and back; head read directly.
// ----------------------------------------------------------------------------
module cnss_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cnss_pkg::job_t push_data,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output cnss_pkg::job_t head
);
	import cnss_pkg::*;

	job_t            slots [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q, rptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push, do_pop;

	assign not_full  = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = slots[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/cnss_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnss_back
// Walks the result mask of the queue head and delivers one result per beat
// through a registered output stage.
// ----------------------------------------------------------------------------
module cnss_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  cnss_pkg::job_t                     head,
	output logic                               pop,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [cnss_pkg::SUM_W-1:0]  neighbor_sum,
	output logic [cnss_pkg::ROW_W-1:0]         out_row,
	output logic [cnss_pkg::COL_W-1:0]         out_col,
	output logic                               last_of_run
);
	import cnss_pkg::*;

	logic [RES_N-1:0] done_q, remaining, pick;
	logic             slot_free, fire, is_last;
	logic signed [SUM_W-1:0] sum_d;
	logic [ROW_W-1:0] row_d;
	logic [COL_W-1:0] col_d;

	always_comb begin
		remaining = head.has & ~done_q;
		pick      = '0;
		sum_d     = head.sum_self;
		row_d     = head.row;
		col_d     = head.col;
		priority if (remaining[RES_ABOVE]) begin
			pick[RES_ABOVE] = 1'b1;
			sum_d = head.sum_above;
			row_d = head.row - ROW_W'(1);
		end else if (remaining[RES_LEFT]) begin
			pick[RES_LEFT] = 1'b1;
			sum_d = head.sum_left;
			col_d = head.col - COL_W'(1);
		end else begin
			pick[RES_SELF] = 1'b1;
		end
		is_last = ((remaining & ~pick) == '0);
	end

	assign slot_free = !result_valid || result_ready;
	assign fire      = slot_free && head_valid;
	assign pop       = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (fire) begin
				result_valid <= 1'b1;
				done_q       <= is_last ? '0 : (done_q | pick);
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			neighbor_sum <= sum_d;
			out_row      <= row_d;
			out_col      <= col_d;
			last_of_run  <= is_last;
		end
	end

endmodule

// ===== rtl/core/cross_neighbor_sum_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_neighbor_sum_stencil
// Five-point neighbor sum over a raster-ordered signed matrix: each result
// is an element plus its up, down, left and right neighbors, with missing
// neighbors counted as zero.
// ----------------------------------------------------------------------------
//
//  channel   handshake                    payload
//  --------  ---------------------------  -----------------------------------
//  item      item_valid / item_ready      element (s16)
//  result    result_valid / result_ready  neighbor_sum (s19), out_row,
//                                         out_col, last_of_run
//  config    APB psel/penable/pwrite      rows_in_use @0x0, cols_in_use @0x4
//
//  One element per cycle while each element causes at most one result and
//  results are taken; in the last row each element past the first causes
//  two (three at the final element), so the single result port paces input.
//  A beat's first result passes the stage-1, queue and output registers.
//  Line buffers come up unwritten; no clearing pass, ready right after reset.
//  A four-entry job queue lets the front keep accepting while results stall.
//
// Structure:
//  - front: position counters, two 1024x16 line-buffer RAMs whose roles swap
//    at every row end, a three-wide window over the previous row, and one
//    register stage that forms all sums an element causes.
//  - queue: holds jobs (up to three sums plus a result mask).
//  - back: emits the masked results of the head job one beat at a time.
// ----------------------------------------------------------------------------
module cross_neighbor_sum_stencil (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cnss_pkg::APB_AW-1:0]          paddr,
	input  logic [cnss_pkg::APB_DW-1:0]          pwdata,
	output logic [cnss_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready,
	// element stream
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic signed [cnss_pkg::ELEM_W-1:0]   element,
	// result stream
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [cnss_pkg::SUM_W-1:0]    neighbor_sum,
	output logic [cnss_pkg::ROW_W-1:0]           out_row,
	output logic [cnss_pkg::COL_W-1:0]           out_col,
	output logic                                 last_of_run
);
	import cnss_pkg::*;

	logic [CFG_W-1:0] rows_q, cols_q;
	logic             cfg_wr;
	cfg_reg_t         reg_sel;

	logic job_valid, q_not_full, q_not_empty, q_pop;
	job_t job, q_head;

	// ---- register file: raw values kept for readback, clamped in the front
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = cfg_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
				REG_COLS: cols_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ROWS: prdata = {{(APB_DW-CFG_W){1'b0}}, rows_q};
			REG_COLS: prdata = {{(APB_DW-CFG_W){1'b0}}, cols_q};
		endcase
	end

	// ---- front: accept, line buffers, sums
	cnss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rows_cfg   (rows_q),
		.cols_cfg   (cols_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.element    (element),
		.job_valid  (job_valid),
		.job_ready  (q_not_full),
		.job        (job)
	);

	// ---- decoupling queue
	cnss_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_data (job),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// ---- back: result sequencing and output register
	cnss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_not_empty),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.neighbor_sum (neighbor_sum),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-point neighbor sum stencil. Raster-order
// elements go in through a clocked driver, and a clocked monitor predicts
// every result and checks the result stream in order. Frame sizes are set
// over the register port between frames, including low values that saturate.
// ----------------------------------------------------------------------------
module tb_top;
	import cnss_pkg::*;

	localparam int          CLK_HALF_NS  = 6;
	localparam int          RESET_CYCLES = 7;
	localparam int          MAX_IDLE     = 8;
	localparam int          HOLD_CYCLES  = 90;   // long output back-pressure
	localparam int          SETTLE       = 6;    // idle beats before each register write
	localparam int          DRAIN_CYCLES = 20;
	localparam int          RANDOM_ITEMS = 245;
	localparam int          REPORT_LIMIT = 10;
	localparam longint      TIMEOUT_NS   = 64'd14_400_000;

	localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
	localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

	// One beat on the result channel as the predictor sees it.
	typedef struct packed {
		logic signed [SUM_W-1:0] nsum;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic                    tail;
	} sum_beat_t;

	// ------------------------------------------------------------------
	// DUT ports; every input starts at a known value.
	// ------------------------------------------------------------------
	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     psel         = 1'b0;
	logic                     penable      = 1'b0;
	logic                     pwrite       = 1'b0;
	logic [APB_AW-1:0]        paddr        = '0;
	logic [APB_DW-1:0]        pwdata       = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     item_valid   = 1'b0;
	logic                     item_ready;
	logic signed [ELEM_W-1:0] element      = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic signed [SUM_W-1:0]  neighbor_sum;
	logic [ROW_W-1:0]         out_row;
	logic [COL_W-1:0]         out_col;
	logic                     last_of_run;

	cross_neighbor_sum_stencil DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.element      (element),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.neighbor_sum (neighbor_sum),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run)
	);

	// ------------------------------------------------------------------
	// Predictor state: two line buffers addressed through a bank select
	// (newer_sel picks the previous row, the other bank holds the row
	// before it and takes the current row in place), the last two
	// elements, the raster position and the raw size registers.
	// ------------------------------------------------------------------
	logic signed [ELEM_W-1:0] line_buf [2][MAX_COLS];
	bit                       newer_sel = 1'b0;
	logic signed [ELEM_W-1:0] recent_0  = '0;
	logic signed [ELEM_W-1:0] recent_1  = '0;
	int unsigned              row_pos   = 0;
	int unsigned              col_pos   = 0;
	logic [CFG_W-1:0]         rows_cfg  = ROWS_RESET;
	logic [CFG_W-1:0]         cols_cfg  = COLS_RESET;

	sum_beat_t                pending_sums[$];      // results still owed by the DUT
	logic signed [ELEM_W-1:0] element_backlog[$];   // elements not yet offered

	// Handshake flags sampled at the rising edge, used at the falling edge.
	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;

	// Per-frame idle limits, set by the stimulus between frames.
	int unsigned src_gap_max    = 0;
	int unsigned sink_stall_max = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;
	bit          hold_go        = 1'b0;
	bit          sink_hold      = 1'b0;

	int unsigned err_count     = 0;
	int unsigned elements_fed  = 0;
	int unsigned results_seen  = 0;
	int unsigned reg_writes    = 0;

	// ------------------------------------------------------------------
	// Clock and reset. Reset drops once, at a falling edge, and stays off.
	// ------------------------------------------------------------------
	always begin
		#(CLK_HALF_NS) clk = 1'b1;
		#(CLK_HALF_NS) clk = 1'b0;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endfunction

	// Size registers saturate into [2, hi].
	function automatic int clip_size(input int unsigned raw, input int unsigned hi);
		if (raw < 2) begin
			return 2;
		end
		return (raw > hi) ? hi : raw;
	endfunction

	// ------------------------------------------------------------------
	// Predictor: one accepted element -> the zero to three results it
	// releases, in emission order (above, left, self), with the tail mark
	// on the last one. Missing neighbors count as zero.
	// ------------------------------------------------------------------
	function automatic void advance_stencil(input logic signed [ELEM_W-1:0] x);
		int n_rows, n_cols, r, c, acc;
		bit has_above, has_left, has_self;
		n_rows = clip_size(rows_cfg, MAX_ROWS);
		n_cols = clip_size(cols_cfg, MAX_COLS);
		r = row_pos;
		c = col_pos;
		if (c >= MAX_COLS) begin
			c = 0;
		end
		has_above = (r >= 1);
		has_left  = (r == n_rows - 1) && (c >= 1) && (c < n_cols);
		has_self  = (r == n_rows - 1) && (c == n_cols - 1);

		// center of the previous row: this element is its down neighbor
		if (has_above) begin
			acc = x + line_buf[newer_sel][c];
			if (r >= 2) begin
				acc += line_buf[!newer_sel][c];
			end
			if (c >= 1) begin
				acc += line_buf[newer_sel][c - 1];
			end
			if (c + 1 < n_cols) begin
				acc += line_buf[newer_sel][c + 1];
			end
			pending_sums.push_back('{nsum: SUM_W'(acc), row: ROW_W'(r - 1),
				col: COL_W'(c), tail: !(has_left || has_self)});
		end
		// last row: the left element now has its right neighbor
		if (has_left) begin
			acc = recent_0 + x + line_buf[newer_sel][c - 1];
			if (c >= 2) begin
				acc += recent_1;
			end
			pending_sums.push_back('{nsum: SUM_W'(acc), row: ROW_W'(r),
				col: COL_W'(c - 1), tail: !has_self});
		end
		// final element of the frame closes itself out
		if (has_self) begin
			acc = x + recent_0 + line_buf[newer_sel][c];
			pending_sums.push_back('{nsum: SUM_W'(acc), row: ROW_W'(r),
				col: COL_W'(c), tail: 1'b1});
		end

		line_buf[!newer_sel][c] = x;
		recent_1 = recent_0;
		recent_0 = x;
		if (c + 1 >= n_cols) begin
			newer_sel = !newer_sel;
			col_pos   = 0;
			row_pos   = (r + 1 >= n_rows) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Element driver: falling edge. Holds a beat until accepted, then
	// waits its drawn gap before offering the next one.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !in_taken) begin
			// beat still waiting, leave it alone
		end else if (gap_left != 0) begin
			gap_left--;
			item_valid <= 1'b0;
		end else if (element_backlog.size() != 0) begin
			element    <= element_backlog.pop_front();
			item_valid <= 1'b1;
			gap_left   = $urandom_range(0, src_gap_max);
		end else begin
			item_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: falling edge. Draws a stall after every beat it
	// takes; the long hold-off overrides everything.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (out_taken) begin
				stall_left = $urandom_range(0, sink_stall_max);
			end
			if (sink_hold) begin
				result_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Long back-pressure window, counted here so the sender keeps going.
	initial begin : sink_holdoff
		wait (hold_go);
		@(posedge clk);
		sink_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: rising edge. Predict on each accepted element first, then
	// check any accepted result against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		sum_beat_t want;
		in_taken  = arst_n && item_valid && item_ready;
		out_taken = arst_n && result_valid && result_ready;
		if (in_taken) begin
			elements_fed++;
			advance_stencil(element);
		end
		if (out_taken) begin
			results_seen++;
			if (pending_sums.size() == 0) begin
				flag_error($sformatf("unexpected result: sum %0d row %0d col %0d last %0b",
					neighbor_sum, out_row, out_col, last_of_run));
			end else begin
				want = pending_sums.pop_front();
				if (neighbor_sum !== want.nsum || out_row !== want.row ||
				    out_col !== want.col || last_of_run !== want.tail) begin
					flag_error($sformatf({"result mismatch: expected sum %0d row %0d",
						" col %0d last %0b, got sum %0d row %0d col %0d last %0b"},
						want.nsum, want.row, want.col, want.tail,
						neighbor_sum, out_row, out_col, last_of_run));
				end
			end
		end
	end

	// Everything offered, accepted and answered. Checked at the rising
	// edge, where the backlog and valid are stable.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (element_backlog.size() != 0 || item_valid || pending_sums.size() != 0);
	endtask

	// Register write (setup + access) followed by a read-back of the same
	// register. Only called with the stream idle.
	task automatic cfg_write(input cfg_reg_t which, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] readback;
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(int'(which) * 4);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (which == REG_ROWS) begin
			rows_cfg = value[CFG_W-1:0];
		end else begin
			cols_cfg = value[CFG_W-1:0];
		end
		reg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== APB_DW'(value[CFG_W-1:0])) begin
			flag_error($sformatf("register %s read back 0x%0h, wrote 0x%0h",
				which.name(), readback, value));
		end
	endtask

	// Mostly full-range values, with the corners showing up often.
	function automatic logic signed [ELEM_W-1:0] random_element();
		case ($urandom_range(0, 9))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return '0;
			3: return '1;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// A size of two is sometimes written as 0 or 1 to hit the low clamp.
	function automatic logic [APB_DW-1:0] size_word(input int unsigned n);
		if (n == 2 && $urandom_range(0, 1)) begin
			return $urandom_range(0, 2);
		end
		return n;
	endfunction

	// One whole frame of random elements; optionally the sender stops
	// halfway until every owed result has come back.
	task automatic play_frame(input int unsigned n_rows, input int unsigned n_cols,
	                          input bit pause_mid);
		int unsigned total;
		total = n_rows * n_cols;
		for (int unsigned k = 0; k < total; k++) begin
			if (pause_mid && k == total / 2) begin
				wait_drained();
			end
			element_backlog.push_back(random_element());
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned n_rows, n_cols, rand_items, frame_idx;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed: reset sizes (3x4) with every element at the minimum, so
		// interior centers reach the most negative sum; back to back.
		for (int k = 0; k < 12; k++) begin
			element_backlog.push_back(ELEM_MIN);
		end
		wait_drained();

		// 3x3 at the maximum: the middle element gets the largest sum.
		src_gap_max    = MAX_IDLE;
		sink_stall_max = MAX_IDLE;
		cfg_write(REG_ROWS, 32'd3);
		cfg_write(REG_COLS, 32'd3);
		for (int k = 0; k < 9; k++) begin
			element_backlog.push_back(ELEM_MAX);
		end
		wait_drained();

		// Smallest frame: every element is a corner, and the final one
		// releases three results.
		cfg_write(REG_ROWS, 32'd2);
		cfg_write(REG_COLS, 32'd2);
		element_backlog.push_back(16'sh5555);
		element_backlog.push_back(16'shAAAA);
		element_backlog.push_back(-16'sd1);
		element_backlog.push_back(16'sd1);
		wait_drained();

		// Random frames of small sizes. Frame 1 runs into the long output
		// hold-off with the sender flat out; frame 3 pauses mid-frame.
		rand_items = 0;
		frame_idx  = 0;
		while (rand_items < RANDOM_ITEMS) begin
			n_rows = $urandom_range(2, 6);
			n_cols = $urandom_range(2, 8);
			src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
			sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
			if (frame_idx == 1) begin
				n_rows      = 6;
				n_cols      = 8;
				src_gap_max = 0;
			end
			cfg_write(REG_ROWS, size_word(n_rows));
			cfg_write(REG_COLS, size_word(n_cols));
			if (frame_idx == 1) begin
				hold_go = 1'b1;
			end
			play_frame(n_rows, n_cols, frame_idx == 3);
			rand_items += n_rows * n_cols;
			frame_idx++;
		end

		// Let any stray beat show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_sums.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_sums.size()));
		end
		$display("Fed %0d elements, checked %0d results, %0d register writes, %0d errors",
			elements_fed, results_seen, reg_writes, err_count);
		$display("Frames from 2x2 to 6x8, low size clamping, gaps, a long stall, a mid-frame drain");
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out: %0d elements waiting, %0d results outstanding",
			element_backlog.size(), pending_sums.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cnss_pkg.sv
rtl/core/cnss_ram.sv
rtl/core/cnss_front.sv
rtl/core/cnss_fifo.sv
rtl/core/cnss_back.sv
rtl/core/cross_neighbor_sum_stencil.sv
test/tb_top.sv
